### src/qsl_pkg.sv
// ----------------------------------------------------------------------------
// qsl_pkg
// Shared constants and controller/datapath interface types for the quicksort
// sorter.
// ----------------------------------------------------------------------------
package qsl_pkg;

	localparam int MAX_ELEMENTS_DEF = 64;
	localparam int VALUE_BITS_DEF   = 32;

	typedef enum logic [4:0] {
		OP_IDLE,
		OP_LOAD,
		OP_START,
		OP_POP,
		OP_RANGE,
		OP_PIVOT,
		OP_PIVLD,
		OP_SCAN,
		OP_SWAP1,
		OP_SKIP,
		OP_SWAP2,
		OP_FIN1,
		OP_FIN2,
		OP_PUSH_HI,
		OP_PUSH_LO,
		OP_OUT_RD,
		OP_OUT_LD,
		OP_CLEAR
	} qsl_op_t;

	typedef struct packed {
		qsl_op_t op;
	} qsl_cmd_t;

	typedef struct packed {
		logic close_seen;
		logic count_lt2;
		logic sp_zero;
		logic scan_eq_hi;
		logic a_lt_pivot;
		logic out_free;
		logic k_done;
	} qsl_status_t;

endpackage

### src/qsl_ctrl.sv
// ----------------------------------------------------------------------------
// qsl_ctrl
// Sequencer for load, partition passes, range stack handling and read-out.
// ----------------------------------------------------------------------------
module qsl_ctrl
	import qsl_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  qsl_status_t status,
	output qsl_cmd_t    cmd
);

	typedef enum logic [3:0] {
		ST_LOAD,
		ST_START,
		ST_POP,
		ST_RANGE,
		ST_PIVOT,
		ST_PIVLD,
		ST_SCAN,
		ST_CMP,
		ST_SWAP2,
		ST_FIN1,
		ST_FIN2,
		ST_PUSH_HI,
		ST_PUSH_LO,
		ST_OUT_RD,
		ST_OUT_LD
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		state_d = state_q;
		cmd.op  = OP_IDLE;
		case (state_q)
			ST_LOAD: begin
				cmd.op = OP_LOAD;
				if (status.close_seen) begin
					state_d = ST_START;
				end
			end
			ST_START: begin
				cmd.op  = OP_START;
				state_d = status.count_lt2 ? ST_OUT_RD : ST_POP;
			end
			ST_POP: begin
				cmd.op  = OP_POP;
				state_d = status.sp_zero ? ST_OUT_RD : ST_RANGE;
			end
			ST_RANGE: begin
				cmd.op  = OP_RANGE;
				state_d = ST_PIVOT;
			end
			ST_PIVOT: begin
				cmd.op  = OP_PIVOT;
				state_d = ST_PIVLD;
			end
			ST_PIVLD: begin
				cmd.op  = OP_PIVLD;
				state_d = ST_SCAN;
			end
			ST_SCAN: begin
				cmd.op  = OP_SCAN;
				state_d = status.scan_eq_hi ? ST_FIN1 : ST_CMP;
			end
			ST_CMP: begin
				if (status.a_lt_pivot) begin
					cmd.op  = OP_SWAP1;
					state_d = ST_SWAP2;
				end else begin
					cmd.op  = OP_SKIP;
					state_d = ST_SCAN;
				end
			end
			ST_SWAP2: begin
				cmd.op  = OP_SWAP2;
				state_d = ST_SCAN;
			end
			ST_FIN1: begin
				cmd.op  = OP_FIN1;
				state_d = ST_FIN2;
			end
			ST_FIN2: begin
				cmd.op  = OP_FIN2;
				state_d = ST_PUSH_HI;
			end
			ST_PUSH_HI: begin
				cmd.op  = OP_PUSH_HI;
				state_d = ST_PUSH_LO;
			end
			ST_PUSH_LO: begin
				cmd.op  = OP_PUSH_LO;
				state_d = ST_POP;
			end
			ST_OUT_RD: begin
				if (status.k_done) begin
					cmd.op  = OP_CLEAR;
					state_d = ST_LOAD;
				end else if (status.out_free) begin
					cmd.op  = OP_OUT_RD;
					state_d = ST_OUT_LD;
				end
			end
			ST_OUT_LD: begin
				cmd.op  = OP_OUT_LD;
				state_d = ST_OUT_RD;
			end
			default: begin
				state_d = ST_LOAD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

### src/qsl_datapath.sv
// ----------------------------------------------------------------------------
// qsl_datapath
// Element memory, range stack memory, partition registers and output word
// register, driven by controller commands.
// ----------------------------------------------------------------------------
module qsl_datapath
	import qsl_pkg::*;
#(
	parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF,
	parameter int VALUE_BITS   = VALUE_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  qsl_cmd_t              cmd,
	output qsl_status_t           status,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [VALUE_BITS-1:0] in_value,
	input  logic                  in_last,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [VALUE_BITS-1:0] out_value,
	output logic                  out_last,
	output logic                  out_dropped
);

	localparam int IDX_W       = $clog2(MAX_ELEMENTS);
	localparam int CNT_W       = $clog2(MAX_ELEMENTS + 1);
	localparam int STACK_DEPTH = MAX_ELEMENTS / 2;
	localparam int SP_W        = $clog2(STACK_DEPTH + 1);
	localparam int SADDR_W     = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int ENTRY_W     = 2 * IDX_W;
	localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_ELEMENTS);

	logic [VALUE_BITS-1:0] elem_mem_q [0:MAX_ELEMENTS-1];
	logic [ENTRY_W-1:0]    stack_mem_q [0:(1 << SADDR_W)-1];

	logic [CNT_W-1:0]      count_q;
	logic                  ovf_q;
	logic [SP_W-1:0]       sp_q;
	logic [CNT_W-1:0]      k_q;
	logic [IDX_W-1:0]      lo_q;
	logic [IDX_W-1:0]      hi_q;
	logic [IDX_W-1:0]      slot_q;
	logic [IDX_W-1:0]      scan_q;
	logic [VALUE_BITS-1:0] pivot_q;
	logic [VALUE_BITS-1:0] rd_a_q;
	logic [VALUE_BITS-1:0] rd_b_q;
	logic [ENTRY_W-1:0]    stk_rd_q;
	logic                  m_valid_q;
	logic [VALUE_BITS-1:0] m_value_q;
	logic                  m_last_q;
	logic                  m_user_q;

	logic                  accept;
	logic                  has_room;
	logic                  we;
	logic [IDX_W-1:0]      waddr;
	logic [VALUE_BITS-1:0] wdata;
	logic                  re_a;
	logic [IDX_W-1:0]      raddr_a;
	logic                  re_b;
	logic                  s_we;
	logic [SADDR_W-1:0]    s_waddr;
	logic [ENTRY_W-1:0]    s_wdata;
	logic                  s_re;
	logic [SP_W-1:0]       sp_dec;
	logic [IDX_W:0]        slot_inc;
	logic                  push_hi_ok;
	logic                  push_lo_ok;
	logic [CNT_W-1:0]      count_dec;
	logic [CNT_W-1:0]      k_inc;

	assign in_ready  = (cmd.op == OP_LOAD);
	assign accept    = in_valid && in_ready;
	assign has_room  = (count_q < MAX_CNT);
	assign sp_dec    = sp_q - SP_W'(1);
	assign slot_inc  = {1'b0, slot_q} + (IDX_W + 1)'(1);
	assign push_hi_ok = (slot_inc < {1'b0, hi_q});
	assign push_lo_ok = ({1'b0, slot_q} > ({1'b0, lo_q} + (IDX_W + 1)'(1)));
	assign count_dec = count_q - CNT_W'(1);
	assign k_inc     = k_q + CNT_W'(1);

	assign status.close_seen = accept && in_last;
	assign status.count_lt2  = (count_q < CNT_W'(2));
	assign status.sp_zero    = (sp_q == '0);
	assign status.scan_eq_hi = (scan_q == hi_q);
	assign status.a_lt_pivot = ($signed(rd_a_q) < $signed(pivot_q));
	assign status.out_free   = !m_valid_q || out_ready;
	assign status.k_done     = (k_q == count_q);

	// element memory port control
	always_comb begin
		we      = 1'b0;
		waddr   = slot_q;
		wdata   = rd_a_q;
		re_a    = 1'b0;
		raddr_a = scan_q;
		re_b    = 1'b0;
		case (cmd.op)
			OP_LOAD: begin
				we    = accept && has_room;
				waddr = count_q[IDX_W-1:0];
				wdata = in_value;
			end
			OP_PIVOT: begin
				re_a    = 1'b1;
				raddr_a = hi_q;
			end
			OP_SCAN: begin
				re_a = 1'b1;
				re_b = 1'b1;
			end
			OP_SWAP1: begin
				we = 1'b1;
			end
			OP_SWAP2: begin
				we    = 1'b1;
				waddr = scan_q;
				wdata = rd_b_q;
			end
			OP_FIN1: begin
				we    = 1'b1;
				wdata = pivot_q;
			end
			OP_FIN2: begin
				we    = 1'b1;
				waddr = hi_q;
				wdata = rd_b_q;
			end
			OP_OUT_RD: begin
				re_a    = 1'b1;
				raddr_a = k_q[IDX_W-1:0];
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			elem_mem_q[waddr] <= wdata;
		end
		if (re_a) begin
			rd_a_q <= elem_mem_q[raddr_a];
		end
		if (re_b) begin
			rd_b_q <= elem_mem_q[slot_q];
		end
	end

	// range stack port control
	always_comb begin
		s_we    = 1'b0;
		s_waddr = sp_q[SADDR_W-1:0];
		s_wdata = {lo_q, hi_q};
		s_re    = 1'b0;
		case (cmd.op)
			OP_START: begin
				s_we    = !status.count_lt2;
				s_waddr = '0;
				s_wdata = {{IDX_W{1'b0}}, count_dec[IDX_W-1:0]};
			end
			OP_POP: begin
				s_re = !status.sp_zero;
			end
			OP_PUSH_HI: begin
				s_we    = push_hi_ok;
				s_wdata = {slot_inc[IDX_W-1:0], hi_q};
			end
			OP_PUSH_LO: begin
				s_we    = push_lo_ok;
				s_wdata = {lo_q, slot_q - IDX_W'(1)};
			end
			default: begin
				s_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (s_we) begin
			stack_mem_q[s_waddr] <= s_wdata;
		end
		if (s_re) begin
			stk_rd_q <= stack_mem_q[sp_dec[SADDR_W-1:0]];
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			ovf_q     <= 1'b0;
			sp_q      <= '0;
			k_q       <= '0;
			m_valid_q <= 1'b0;
		end else begin
			if (m_valid_q && out_ready) begin
				m_valid_q <= 1'b0;
			end
			case (cmd.op)
				OP_LOAD: begin
					if (accept && has_room) begin
						count_q <= count_q + CNT_W'(1);
					end
					if (accept && !has_room) begin
						ovf_q <= 1'b1;
					end
				end
				OP_START: begin
					k_q  <= '0;
					sp_q <= status.count_lt2 ? '0 : SP_W'(1);
				end
				OP_POP: begin
					if (!status.sp_zero) begin
						sp_q <= sp_dec;
					end
				end
				OP_PUSH_HI: begin
					if (push_hi_ok) begin
						sp_q <= sp_q + SP_W'(1);
					end
				end
				OP_PUSH_LO: begin
					if (push_lo_ok) begin
						sp_q <= sp_q + SP_W'(1);
					end
				end
				OP_OUT_LD: begin
					m_valid_q <= 1'b1;
					k_q       <= k_inc;
				end
				OP_CLEAR: begin
					count_q <= '0;
					ovf_q   <= 1'b0;
					sp_q    <= '0;
				end
				default: begin
					k_q <= k_q;
				end
			endcase
		end
	end

	// partition and output payload registers
	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_RANGE: begin
				lo_q <= stk_rd_q[ENTRY_W-1:IDX_W];
				hi_q <= stk_rd_q[IDX_W-1:0];
			end
			OP_PIVOT: begin
				slot_q <= lo_q;
				scan_q <= lo_q;
			end
			OP_PIVLD: begin
				pivot_q <= rd_a_q;
			end
			OP_SKIP: begin
				scan_q <= scan_q + IDX_W'(1);
			end
			OP_SWAP2: begin
				slot_q <= slot_q + IDX_W'(1);
				scan_q <= scan_q + IDX_W'(1);
			end
			OP_OUT_LD: begin
				m_value_q <= rd_a_q;
				m_last_q  <= (k_inc == count_q);
				m_user_q  <= ovf_q;
			end
			default: begin
				pivot_q <= pivot_q;
			end
		endcase
	end

	assign out_valid   = m_valid_q;
	assign out_value   = m_value_q;
	assign out_last    = m_last_q;
	assign out_dropped = m_user_q;

endmodule

### src/quicksort_lomuto_sorter.sv
// ----------------------------------------------------------------------------
// quicksort_lomuto_sorter
// Collects a set of signed values, sorts them ascending by quicksort with
// Lomuto partition and an explicit range stack, then streams them out.
// ----------------------------------------------------------------------------
// Loading takes one word per cycle, the word with tlast closing the set. The
// sort runs on a single element memory with one write port and two read
// ports: a popped range passes pop, setup, finish and two push steps, plus
// scan and compare steps per scanned element, a second swap step per swap;
// sort start and the final empty pop are steps of their own. Each word is
// read, then loaded into the output register when free. The input is not
// ready from the closing word until the clearing step after the last sorted
// word is loaded. Words beyond MAX_ELEMENTS are discarded; every output word
// of that set carries tuser set. No clearing pass after reset.
module quicksort_lomuto_sorter
	import qsl_pkg::*;
#(
	parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF,
	parameter int VALUE_BITS   = VALUE_BITS_DEF,
	localparam int DATA_W      = ((VALUE_BITS + 7) / 8) * 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_axis_tvalid,
	output logic              s_axis_tready,
	input  logic [DATA_W-1:0] s_axis_tdata,  // value
	input  logic              s_axis_tlast,
	output logic              m_axis_tvalid,
	input  logic              m_axis_tready,
	output logic [DATA_W-1:0] m_axis_tdata,  // value_res
	output logic              m_axis_tlast,
	output logic              m_axis_tuser   // dropped
);

	qsl_cmd_t              cmd;
	qsl_status_t           status;
	logic [VALUE_BITS-1:0] out_value;

	qsl_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.status (status),
		.cmd    (cmd)
	);

	qsl_datapath #(
		.MAX_ELEMENTS (MAX_ELEMENTS),
		.VALUE_BITS   (VALUE_BITS)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.status      (status),
		.in_valid    (s_axis_tvalid),
		.in_ready    (s_axis_tready),
		.in_value    (s_axis_tdata[VALUE_BITS-1:0]),
		.in_last     (s_axis_tlast),
		.out_valid   (m_axis_tvalid),
		.out_ready   (m_axis_tready),
		.out_value   (out_value),
		.out_last    (m_axis_tlast),
		.out_dropped (m_axis_tuser)
	);

	assign m_axis_tdata = DATA_W'(out_value);

endmodule
